[design/lohc_pkg.sv]
// Shared types, codes and constants for the LRU open-handle cache.
// Used by lohc_cell and lru_open_handle_cache; depends on nothing else.
package lohc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;

    localparam logic [1:0] KIND_OPEN      = 2'd0;
    localparam logic [1:0] KIND_CLOSE     = 2'd1;
    localparam logic [1:0] KIND_CLOSE_ALL = 2'd2;

    localparam logic [2:0] STAT_HIT        = 3'd0;
    localparam logic [2:0] STAT_FILLED     = 3'd1;
    localparam logic [2:0] STAT_FAILED     = 3'd2;
    localparam logic [2:0] STAT_EMPTY      = 3'd3;
    localparam logic [2:0] STAT_CLOSED     = 3'd4;
    localparam logic [2:0] STAT_NOTFOUND   = 3'd5;
    localparam logic [2:0] STAT_ALL_CLOSED = 3'd6;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_STAMP,
        CMD_FILL,
        CMD_CLEAR,
        CMD_CLEAR_ALL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        key_t    key;
        stamp_t  stamp;
    } cmd_t;

    // Search record handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic   go;
        idx_t   pos;
        logic   hit;
        idx_t   hit_idx;
        logic   have_best;
        idx_t   best_idx;
        stamp_t best_stamp;
        logic   best_valid;
        key_t   best_key;
    } token_t;

    function automatic logic [2:0] to_slot(input idx_t idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[2:0];
    endfunction

endpackage

[design/lohc_cell.sv]
// One cache slot: key, valid bit and use stamp, plus one stage of the search chain.
// Depends on lohc_pkg for the token and command types.
module lohc_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  lohc_pkg::key_t    qkey,
    input  lohc_pkg::token_t  tok_in,
    output lohc_pkg::token_t  tok_out,
    input  lohc_pkg::cmd_t    cmd,
    input  logic              sel
);

    lohc_pkg::key_t   key_reg;
    logic             valid_reg;
    lohc_pkg::stamp_t stamp_reg;
    lohc_pkg::token_t tok_reg;
    lohc_pkg::token_t tok_next;

    always_comb begin
        tok_next     = tok_in;
        tok_next.pos = tok_in.pos + lohc_pkg::idx_t'(1);
        if (!tok_in.hit && valid_reg && (key_reg == qkey)) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = tok_in.pos;
        end
        if (!tok_in.have_best || (stamp_reg < tok_in.best_stamp)) begin
            tok_next.have_best  = 1'b1;
            tok_next.best_idx   = tok_in.pos;
            tok_next.best_stamp = stamp_reg;
            tok_next.best_valid = valid_reg;
            tok_next.best_key   = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            valid_reg <= 1'b0;
            stamp_reg <= '0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (cmd.op == lohc_pkg::CMD_CLEAR_ALL) begin
                key_reg   <= '0;
                valid_reg <= 1'b0;
                stamp_reg <= '0;
            end else if (sel) begin
                case (cmd.op)
                    lohc_pkg::CMD_STAMP: begin
                        stamp_reg <= cmd.stamp;
                    end
                    lohc_pkg::CMD_FILL: begin
                        key_reg   <= cmd.key;
                        valid_reg <= 1'b1;
                        stamp_reg <= cmd.stamp;
                    end
                    lohc_pkg::CMD_CLEAR: begin
                        key_reg   <= '0;
                        valid_reg <= 1'b0;
                        stamp_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

[design/lru_open_handle_cache.sv]
// Top level of the LRU open-handle cache: request control and the chain of slot cells.
// Depends on lohc_pkg and lohc_cell.
// An open or close-one request with a nonzero key starts a search: the start register, then the
// search record passing one slot cell per cycle, then the output register. Empty keys, close-all
// and unused kinds are answered without a search. One transaction is in flight at a time.
// Synchronous active-low reset clears every slot, the use clock and the output register.
module lru_open_handle_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // key [63:0], open_ok [64], zero fill [71:65]
    input  logic [1:0]  s_tuser,  // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // slot [2:0], evicted_valid [3], evicted_key [67:4], zero [71:68]
    output logic [2:0]  m_tuser   // status [2:0]
);

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t           state_reg;
    lohc_pkg::stamp_t clock_reg;
    logic             start_reg;
    logic [1:0]       kind_reg;
    lohc_pkg::key_t   key_reg;
    logic             ok_reg;
    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic [2:0]       m_slot_reg;
    logic             m_ev_valid_reg;
    lohc_pkg::key_t   m_ev_key_reg;

    logic             accept;
    logic [1:0]       in_kind;
    lohc_pkg::key_t   in_key;
    logic             need_scan;
    logic             res_valid;
    logic [2:0]       res_status;
    logic [2:0]       res_slot;
    logic             res_ev_valid;
    lohc_pkg::key_t   res_ev_key;
    lohc_pkg::cmd_t   cmd;
    lohc_pkg::idx_t   cmd_idx;
    logic [lohc_pkg::ENTRIES-1:0] sel;
    lohc_pkg::token_t tok_w [lohc_pkg::ENTRIES+1];
    lohc_pkg::token_t tail;

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_key   = s_tdata[63:0];
    assign tail     = tok_w[lohc_pkg::ENTRIES];

    always_comb begin
        tok_w[0]    = '0;
        tok_w[0].go = start_reg;
    end

    always_comb begin
        need_scan    = 1'b0;
        res_valid    = 1'b0;
        res_status   = lohc_pkg::STAT_NOTFOUND;
        res_slot     = 3'd0;
        res_ev_valid = 1'b0;
        res_ev_key   = '0;
        cmd.op       = lohc_pkg::CMD_NONE;
        cmd.key      = key_reg;
        cmd.stamp    = clock_reg;
        cmd_idx      = '0;
        if (accept) begin
            case (in_kind)
                lohc_pkg::KIND_OPEN: begin
                    if (in_key == '0) begin
                        res_valid  = 1'b1;
                        res_status = lohc_pkg::STAT_EMPTY;
                    end else begin
                        need_scan = 1'b1;
                    end
                end
                lohc_pkg::KIND_CLOSE: begin
                    if (in_key == '0) begin
                        res_valid = 1'b1;
                    end else begin
                        need_scan = 1'b1;
                    end
                end
                lohc_pkg::KIND_CLOSE_ALL: begin
                    res_valid  = 1'b1;
                    res_status = lohc_pkg::STAT_ALL_CLOSED;
                    cmd.op     = lohc_pkg::CMD_CLEAR_ALL;
                end
                default: begin
                    res_valid = 1'b1;
                end
            endcase
        end else if ((state_reg == ST_SCAN) && tail.go) begin
            res_valid = 1'b1;
            if (kind_reg == lohc_pkg::KIND_OPEN) begin
                if (tail.hit) begin
                    cmd.op     = lohc_pkg::CMD_STAMP;
                    cmd_idx    = tail.hit_idx;
                    res_status = lohc_pkg::STAT_HIT;
                    res_slot   = lohc_pkg::to_slot(tail.hit_idx);
                end else begin
                    cmd_idx      = tail.best_idx;
                    res_slot     = lohc_pkg::to_slot(tail.best_idx);
                    res_ev_valid = tail.best_valid;
                    res_ev_key   = tail.best_valid ? tail.best_key : '0;
                    if (ok_reg) begin
                        cmd.op     = lohc_pkg::CMD_FILL;
                        res_status = lohc_pkg::STAT_FILLED;
                    end else begin
                        cmd.op     = lohc_pkg::CMD_CLEAR;
                        res_status = lohc_pkg::STAT_FAILED;
                    end
                end
            end else if (tail.hit) begin
                cmd.op     = lohc_pkg::CMD_CLEAR;
                cmd_idx    = tail.hit_idx;
                res_status = lohc_pkg::STAT_CLOSED;
                res_slot   = lohc_pkg::to_slot(tail.hit_idx);
            end
        end
    end

    for (genvar i = 0; i < lohc_pkg::ENTRIES; i++) begin : g_cell
        assign sel[i] = (cmd_idx == lohc_pkg::idx_t'(i));
        lohc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .qkey    (key_reg),
            .tok_in  (tok_w[i]),
            .tok_out (tok_w[i+1]),
            .cmd     (cmd),
            .sel     (sel[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clock_reg      <= '0;
            start_reg      <= 1'b0;
            kind_reg       <= lohc_pkg::KIND_OPEN;
            key_reg        <= '0;
            ok_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= lohc_pkg::STAT_NOTFOUND;
            m_slot_reg     <= 3'd0;
            m_ev_valid_reg <= 1'b0;
            m_ev_key_reg   <= '0;
        end else begin
            start_reg <= accept && need_scan;
            if (accept) begin
                kind_reg <= in_kind;
                key_reg  <= in_key;
                ok_reg   <= s_tdata[64];
                if ((in_kind == lohc_pkg::KIND_OPEN) && (in_key != '0)) begin
                    clock_reg <= clock_reg + lohc_pkg::stamp_t'(1);
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && need_scan) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (tail.go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (res_valid) begin
                m_valid_reg    <= 1'b1;
                m_status_reg   <= res_status;
                m_slot_reg     <= res_slot;
                m_ev_valid_reg <= res_ev_valid;
                m_ev_key_reg   <= res_ev_key;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_ev_key_reg, m_ev_valid_reg, m_slot_reg};

    a_no_accept_while_pending: assert property (
        @(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid)
    ) else $error("transaction accepted while a result is pending");

    a_tail_only_in_scan: assert property (
        @(posedge aclk) disable iff (!aresetn) tail.go |-> (state_reg == ST_SCAN)
    ) else $error("search record left the chain outside a search");

    a_single_target: assert property (
        @(posedge aclk) disable iff (!aresetn) $onehot(sel)
    ) else $error("slot select is not one-hot");

    a_evict_on_miss: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |->
            (m_tuser == lohc_pkg::STAT_FILLED || m_tuser == lohc_pkg::STAT_FAILED)
    ) else $error("eviction reported outside an open miss");

    a_result_has_cause: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(accept || ((state_reg == ST_SCAN) && tail.go))
    ) else $error("result appeared without a request");

endmodule
